// ===== rtl/usrf_pkg.sv =====
// ----------------------------------------------------------------------------
// usrf_pkg
// Shared codes, register offsets, bit positions and the result word type
// for the uart register interface with receive fifo.
// ----------------------------------------------------------------------------
package usrf_pkg;

   localparam int DATA_W = 32;
   localparam int BYTE_W = 8;
   localparam int CMD_W  = 2;
   localparam int IDX_W  = 3;

   // item kinds
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RX    = 2'd2;

   // word offsets
   localparam logic [IDX_W-1:0] REG_STATUS = 3'd0;
   localparam logic [IDX_W-1:0] REG_DATA   = 3'd1;
   localparam logic [IDX_W-1:0] REG_BAUD   = 3'd2;
   localparam logic [IDX_W-1:0] REG_CTL0   = 3'd3;
   localparam logic [IDX_W-1:0] REG_CTL1   = 3'd4;
   localparam logic [IDX_W-1:0] REG_CTL2   = 3'd5;
   localparam logic [IDX_W-1:0] REG_GUARD  = 3'd6;

   // status and ctl0 bit positions
   localparam int STAT_TBE_BIT    = 7;
   localparam int STAT_RBNE_BIT   = 5;
   localparam int CTL0_TCIE_BIT   = 6;
   localparam int CTL0_RBNEIE_BIT = 5;
   localparam int CTL0_TEN_BIT    = 3;
   localparam int CTL0_REN_BIT    = 2;

   localparam logic [DATA_W-1:0] STATUS_RESET = 32'h0000_00C0;

   // one result word
   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              tx_valid;
      logic [BYTE_W-1:0] tx_byte;
      logic              irq_level;
      logic              rx_dropped;
      logic              rx_ready;
   } rsp_type;

endpackage

// ===== rtl/usrf_core.sv =====
// ----------------------------------------------------------------------------
// usrf_core
// Register file, receive fifo and interrupt logic. Each accepted word is
// decoded and applied when it is accepted; its result lands in the stage register.
// ----------------------------------------------------------------------------
module usrf_core #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [usrf_pkg::CMD_W-1:0]           req_cmd,
   input  logic [usrf_pkg::IDX_W-1:0]           req_reg_index,
   input  logic [usrf_pkg::DATA_W-1:0]          req_write_data,
   input  logic [usrf_pkg::BYTE_W-1:0]          req_rx_byte,
   output logic                                 stage_valid,
   output usrf_pkg::rsp_type                    stage_rsp,
   input  logic                                 stage_ready
);
   import usrf_pkg::*;

   localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(FIFO_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

   logic [DATA_W-1:0] status_ff, status_in;
   logic [DATA_W-1:0] baud_ff, ctl0_ff, ctl1_ff, ctl2_ff, guard_ff;
   logic [BYTE_W-1:0] fifo_mem [FIFO_DEPTH];
   logic [AW-1:0]     head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              irq_ff, irq_in;
   logic              stage_valid_ff;
   rsp_type           stage_rsp_ff, stage_rsp_in;

   logic accept, is_read, is_write, is_rx;
   logic pop, push, drop, tx, recompute, irq_calc;
   logic [DATA_W-1:0] reg_rd;

   // handshake
   assign req_ready = !stage_valid_ff || stage_ready;
   assign accept    = req_valid && req_ready;

   // decode
   assign is_read  = (req_cmd == CMD_READ);
   assign is_write = (req_cmd == CMD_WRITE);
   assign is_rx    = (req_cmd == CMD_RX);
   assign pop      = is_read && (req_reg_index == REG_DATA) && (count_ff != '0);
   assign push     = is_rx && (count_ff != FULL_CNT);
   assign drop     = is_rx && (count_ff == FULL_CNT);
   assign tx       = is_write && (req_reg_index == REG_DATA);
   assign recompute = pop || push || tx || (is_write && (req_reg_index == REG_CTL1));

   // fifo pointers and fill count
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in  = (head_ff == LAST_PTR) ? '0 : head_ff + AW'(1);
         count_in = count_ff - CW'(1);
      end
      if (push) begin
         tail_in  = (tail_ff == LAST_PTR) ? '0 : tail_ff + AW'(1);
         count_in = count_ff + CW'(1);
      end
   end

   // interrupt level from ctl0 and the fill count after this word
   assign irq_calc = (ctl0_ff[CTL0_TCIE_BIT] && ctl0_ff[CTL0_TEN_BIT]) ||
                     (ctl0_ff[CTL0_RBNEIE_BIT] && ctl0_ff[CTL0_REN_BIT] &&
                      (count_in != '0));
   assign irq_in = recompute ? irq_calc : irq_ff;

   // status register next value
   always_comb begin
      status_in = status_ff;
      if (is_write && (req_reg_index == REG_STATUS)) begin
         status_in = req_write_data;
      end else if (recompute) begin
         status_in[STAT_TBE_BIT]  = 1'b1;
         status_in[STAT_RBNE_BIT] = (count_in != '0);
      end
   end

   // register read mux, data word comes from the fifo memory
   always_comb begin
      unique case (req_reg_index)
         REG_STATUS: reg_rd = status_ff;
         REG_BAUD:   reg_rd = baud_ff;
         REG_CTL0:   reg_rd = ctl0_ff;
         REG_CTL1:   reg_rd = ctl1_ff;
         REG_CTL2:   reg_rd = ctl2_ff;
         REG_GUARD:  reg_rd = guard_ff;
         default:    reg_rd = '0;
      endcase
   end

   // result word, read data patched with the popped byte below
   always_comb begin
      stage_rsp_in.read_data  = is_read ? reg_rd : '0;
      stage_rsp_in.tx_valid   = tx;
      stage_rsp_in.tx_byte    = tx ? req_write_data[BYTE_W-1:0] : '0;
      stage_rsp_in.irq_level  = irq_in;
      stage_rsp_in.rx_dropped = drop;
      stage_rsp_in.rx_ready   = (count_in != FULL_CNT);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff      <= STATUS_RESET;
         baud_ff        <= '0;
         ctl0_ff        <= '0;
         ctl1_ff        <= '0;
         ctl2_ff        <= '0;
         guard_ff       <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         irq_ff         <= 1'b0;
         stage_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            status_ff <= status_in;
            head_ff   <= head_in;
            tail_ff   <= tail_in;
            count_ff  <= count_in;
            irq_ff    <= irq_in;
            if (is_write) begin
               unique case (req_reg_index)
                  REG_BAUD:  baud_ff  <= req_write_data;
                  REG_CTL0:  ctl0_ff  <= req_write_data;
                  REG_CTL1:  ctl1_ff  <= req_write_data;
                  REG_CTL2:  ctl2_ff  <= req_write_data;
                  REG_GUARD: guard_ff <= req_write_data;
                  default:   ;
               endcase
            end
            stage_valid_ff <= 1'b1;
         end else if (stage_ready) begin
            stage_valid_ff <= 1'b0;
         end
      end
   end

   // fifo memory and stage payload, popped byte read straight into the stage
   always_ff @(posedge clock) begin
      if (accept && push) begin
         fifo_mem[tail_ff] <= req_rx_byte;
      end
      if (accept) begin
         if (pop) begin
            // popped byte replaces the read data field
            stage_rsp_ff <= {{(DATA_W-BYTE_W){1'b0}}, fifo_mem[head_ff],
                             stage_rsp_in.tx_valid, stage_rsp_in.tx_byte,
                             stage_rsp_in.irq_level, stage_rsp_in.rx_dropped,
                             stage_rsp_in.rx_ready};
         end else begin
            stage_rsp_ff <= stage_rsp_in;
         end
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage_rsp   = stage_rsp_ff;

`ifndef SYNTH
   // fill count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("fifo count above depth");

   // a pop takes exactly one byte out
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      accept && pop |=> count_ff == $past(count_ff) - CW'(1))
      else $error("pop did not decrement count");

   // after a recompute rbne tracks the fifo
   a_rbne: assert property (@(posedge clock) disable iff (reset)
      accept && recompute |=> status_ff[STAT_RBNE_BIT] == (count_ff != '0))
      else $error("rbne out of step with fifo");

   // a stalled stage holds its word
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !stage_ready |=> stage_valid_ff && $stable(stage_rsp_ff))
      else $error("stage word lost under stall");
`endif

endmodule

// ===== rtl/usrf_skid.sv =====
// ----------------------------------------------------------------------------
// usrf_skid
// Skid buffer on the result side: holds one extra word so the stage
// register can drain while the receiver stalls.
// ----------------------------------------------------------------------------
module usrf_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  usrf_pkg::rsp_type in_rsp,
   output logic              out_valid,
   input  logic              out_ready,
   output usrf_pkg::rsp_type out_rsp
);
   import usrf_pkg::*;

   logic    skid_valid_ff;
   rsp_type skid_ff;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = in_valid || skid_valid_ff;
   assign out_rsp   = skid_valid_ff ? skid_ff : in_rsp;

   // catch the word when the receiver stalls, release when it takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (in_valid && !out_ready) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff && in_valid && !out_ready) begin
         skid_ff <= in_rsp;
      end
   end

endmodule

// ===== rtl/usart_registers_with_rx_fifo_core.sv =====
// ----------------------------------------------------------------------------
// usart_registers_with_rx_fifo_core
// Uart register interface with a receive fifo, one result word per item.
// ----------------------------------------------------------------------------
// Request channel (req_*): each word is a bus read, a bus write or a byte
// received from the line, selected by req_cmd. Every request gives exactly
// one response word on the rsp_* channel, in order.
// Response: it is registered in the stage register and presented once the skid buffer is empty.
// Throughput: one request per cycle while the response side does not stall;
// all register, fifo pointer and interrupt updates settle in the cycle the request is accepted, and a
// popped byte is read from the fifo memory straight into the stage register.
// Stall: a stage register plus a one-word skid buffer sit on the response
// side, so one more request is taken while a response waits; req_ready
// drops only when both hold a word.
// Reset: status returns to 0xC0, the other registers, fifo count and
// interrupt level clear; fifo contents are not cleared and never need to be,
// since only written entries are read.
// ----------------------------------------------------------------------------
module usart_registers_with_rx_fifo_core #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [usrf_pkg::CMD_W-1:0]  req_cmd,
   input  logic [usrf_pkg::IDX_W-1:0]  req_reg_index,
   input  logic [usrf_pkg::DATA_W-1:0] req_write_data,
   input  logic [usrf_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [usrf_pkg::DATA_W-1:0] rsp_read_data,
   output logic                        rsp_tx_valid,
   output logic [usrf_pkg::BYTE_W-1:0] rsp_tx_byte,
   output logic                        rsp_irq_level,
   output logic                        rsp_rx_dropped,
   output logic                        rsp_rx_ready
);
   import usrf_pkg::*;

   logic    stage_valid, stage_ready;
   rsp_type stage_rsp, out_rsp;

   // register file, fifo and interrupt
   usrf_core #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .req_rx_byte    (req_rx_byte),
      .stage_valid    (stage_valid),
      .stage_rsp      (stage_rsp),
      .stage_ready    (stage_ready)
   );

   // response skid buffer
   usrf_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid),
      .in_ready  (stage_ready),
      .in_rsp    (stage_rsp),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rsp   (out_rsp)
   );

   assign rsp_read_data  = out_rsp.read_data;
   assign rsp_tx_valid   = out_rsp.tx_valid;
   assign rsp_tx_byte    = out_rsp.tx_byte;
   assign rsp_irq_level  = out_rsp.irq_level;
   assign rsp_rx_dropped = out_rsp.rx_dropped;
   assign rsp_rx_ready   = out_rsp.rx_ready;

endmodule
